[hw/rtl/mtdi_pkg.sv]
package mtdi_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int DATA_W     = 32;
	localparam int ACCEL_W    = 31;
	localparam int ADDR_W     = 3;
	localparam int B_W        = DATA_W + 2;
	localparam int RAD_W      = 68;
	localparam int ROOT_W     = RAD_W / 2;
	localparam int REM_W      = ROOT_W + 3;
	localparam int N_W        = ROOT_W + 2;
	localparam int NMAG_W     = ROOT_W;
	localparam int NUM_W      = NMAG_W + FRAC_BITS;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	localparam logic [ACCEL_W-1:0] ACCEL_RESET = ACCEL_W'(1) << FRAC_BITS;
	localparam logic [ADDR_W-3:0]  REG_ACCEL   = '0;

	typedef struct packed {
		logic [RAD_W-1:0]        radp;
		logic [RAD_W-1:0]        radn;
		logic                    okp;
		logic                    okn;
		logic signed [B_W-1:0]   b;
	} job_t;

endpackage

[hw/rtl/mtdi_in_if.sv]
interface mtdi_in_if;
	logic                     valid;
	logic                     ready;
	logic signed [31:0]       start_pos;
	logic signed [31:0]       end_pos;
	logic signed [31:0]       start_vel;
	logic signed [31:0]       end_vel;

	modport source(output valid, start_pos, end_pos, start_vel, end_vel, input ready);
	modport sink(input valid, start_pos, end_pos, start_vel, end_vel, output ready);
endinterface

[hw/rtl/mtdi_out_if.sv]
interface mtdi_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] min_time;
	logic        no_solution;
	logic        saturated;

	modport source(output valid, min_time, no_solution, saturated, input ready);
	modport sink(input valid, min_time, no_solution, saturated, output ready);
endinterface

[hw/rtl/mtdi_cfg.sv]
module mtdi_cfg
	import mtdi_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output logic [ACCEL_W-1:0] accel
);

	logic [ACCEL_W-1:0] accel_q;

	assign pready = 1'b1;
	assign accel  = accel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_q <= ACCEL_RESET;
		end else if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_ACCEL) begin
			accel_q <= pwdata[ACCEL_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[ADDR_W-1:2] == REG_ACCEL) begin
			prdata = 32'(accel_q);
		end
	end

endmodule

[hw/rtl/mtdi_front.sv]
module mtdi_front
	import mtdi_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	mtdi_in_if.sink            items,
	input  logic [ACCEL_W-1:0] accel,
	input  logic               full,
	output logic               push,
	output job_t               job
);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4;

	logic [31:0]           m0_s1, m1_s1, mdx_s1;
	logic                  dxneg_s1, dxneg_s2, dxneg_s3;
	logic signed [B_W-1:0] b_s1, b_s2, b_s3;
	logic [63:0]           sq0_s2, sq1_s2, q_s3, p_s3;
	logic [62:0]           pa_s2;
	job_t                  job_s4;

	logic signed [32:0]    dx_c;
	logic signed [B_W-1:0] vsum_c;
	logic [64:0]           sum_c, wp_c, wn_c;
	logic [63:0]           diff_c;
	logic                  ge_c;
	job_t                  job_c;

	assign en          = !v_s4 || !full;
	assign items.ready = en;
	assign push        = v_s4 && !full;
	assign job         = job_s4;

	assign dx_c   = {items.end_pos[31], items.end_pos} - {items.start_pos[31], items.start_pos};
	assign vsum_c = {{2{items.start_vel[31]}}, items.start_vel}
			+ {{2{items.end_vel[31]}}, items.end_vel};

	always_comb begin
		sum_c  = {1'b0, q_s3} + {1'b0, p_s3};
		diff_c = q_s3 - p_s3;
		ge_c   = q_s3 >= p_s3;
		// positive acceleration adds 2*a*|dx| when dx is non-negative, negative one when dx < 0
		wp_c   = dxneg_s3 ? {1'b0, diff_c} : sum_c;
		wn_c   = dxneg_s3 ? sum_c : {1'b0, diff_c};
		job_c.radp = RAD_W'({wp_c, 1'b0});
		job_c.radn = RAD_W'({wn_c, 1'b0});
		job_c.okp  = !dxneg_s3 || ge_c;
		job_c.okn  = dxneg_s3 || ge_c;
		job_c.b    = b_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= items.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m0_s1    <= items.start_vel[31] ? 32'(-items.start_vel) : items.start_vel;
			m1_s1    <= items.end_vel[31] ? 32'(-items.end_vel) : items.end_vel;
			mdx_s1   <= dx_c[32] ? 32'(-dx_c) : dx_c[31:0];
			dxneg_s1 <= dx_c[32];
			b_s1     <= -vsum_c;

			sq0_s2   <= 64'(m0_s1) * 64'(m0_s1);
			sq1_s2   <= 64'(m1_s1) * 64'(m1_s1);
			pa_s2    <= 63'(accel) * 63'(mdx_s1);
			dxneg_s2 <= dxneg_s1;
			b_s2     <= b_s1;

			q_s3     <= sq0_s2 + sq1_s2;
			p_s3     <= {pa_s2, 1'b0};
			dxneg_s3 <= dxneg_s2;
			b_s3     <= b_s2;

			job_s4   <= job_c;
		end
	end

endmodule

[hw/rtl/mtdi_fifo.sv]
module mtdi_fifo
	import mtdi_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_data,
	output logic full,
	input  logic pop,
	output logic nonempty,
	output job_t pop_data
);

	job_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full     = cnt_q == CNT_W'(FIFO_DEPTH);
	assign nonempty = cnt_q != '0;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

endmodule

[hw/rtl/mtdi_back.sv]
module mtdi_back
	import mtdi_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic [ACCEL_W-1:0] accel,
	input  logic               nonempty,
	input  job_t               job,
	output logic               pop,
	mtdi_out_if.source         results
);

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sq_t;

	function automatic sq_t sq_step(sq_t c, logic [1:0] d);
		logic [REM_W-1:0] r4;
		logic [REM_W-1:0] tr;
		sq_t n;
		r4 = {c.rem[REM_W-3:0], d};
		tr = REM_W'({c.root, 2'b01});
		if (r4 >= tr) begin
			n.rem  = r4 - tr;
			n.root = {c.root[ROOT_W-2:0], 1'b1};
		end else begin
			n.rem  = r4;
			n.root = {c.root[ROOT_W-2:0], 1'b0};
		end
		return n;
	endfunction

	typedef struct packed {
		logic              v;
		logic [NMAG_W-1:0] m;
	} cand_t;

	function automatic cand_t pick(cand_t a, cand_t b);
		if (a.v && (!b.v || a.m <= b.m)) return a;
		return b;
	endfunction

	function automatic logic [NMAG_W-1:0] mag(logic signed [N_W-1:0] n);
		return n[N_W-1] ? NMAG_W'(-n) : NMAG_W'(n);
	endfunction

	localparam int RW = ACCEL_W + 1;

	logic en;

	// square root lanes, one stage per root bit
	logic                  sv_q   [ROOT_W+1];
	sq_t                   sqp_q  [ROOT_W+1];
	sq_t                   sqn_q  [ROOT_W+1];
	logic [RAD_W-1:0]      radp_q [ROOT_W+1];
	logic [RAD_W-1:0]      radn_q [ROOT_W+1];
	logic                  okp_q  [ROOT_W+1];
	logic                  okn_q  [ROOT_W+1];
	logic signed [B_W-1:0] b_q    [ROOT_W+1];

	logic  v_s1, v_s2, v_s3;
	cand_t c_s1 [4];
	cand_t c_s2 [2];
	cand_t c_s3;

	// restoring divider, one quotient bit per stage
	logic             dv_q  [NUM_W+1];
	logic             dfd_q [NUM_W+1];
	logic [RW-1:0]    drem_q[NUM_W+1];
	logic [NUM_W-1:0] dnq_q [NUM_W+1];

	logic        v_out_q, nosol_q, sat_q;
	logic [31:0] time_q;

	logic signed [N_W-1:0] bx_c, rp_c, rn_c;
	logic signed [N_W-1:0] np1_c, np2_c, nn1_c, nn2_c;
	logic [NUM_W-1:0]      quo_c;

	assign en  = !v_out_q || results.ready;
	assign pop = en && nonempty;

	assign results.valid       = v_out_q;
	assign results.min_time    = time_q;
	assign results.no_solution = nosol_q;
	assign results.saturated   = sat_q;

	assign bx_c  = N_W'(b_q[ROOT_W]);
	assign rp_c  = N_W'(sqp_q[ROOT_W].root);
	assign rn_c  = N_W'(sqn_q[ROOT_W].root);
	assign np1_c = bx_c + rp_c;
	assign np2_c = bx_c - rp_c;
	assign nn1_c = bx_c + rn_c;
	assign nn2_c = bx_c - rn_c;
	assign quo_c = dnq_q[NUM_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= ROOT_W; k++) sv_q[k] <= 1'b0;
			for (int k = 0; k <= NUM_W; k++) dv_q[k] <= 1'b0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_out_q <= 1'b0;
		end else if (en) begin
			sv_q[0] <= nonempty;
			for (int k = 0; k < ROOT_W; k++) sv_q[k+1] <= sv_q[k];
			v_s1    <= sv_q[ROOT_W];
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			dv_q[0] <= v_s3;
			for (int k = 0; k < NUM_W; k++) dv_q[k+1] <= dv_q[k];
			v_out_q <= dv_q[NUM_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqp_q[0]  <= '0;
			sqn_q[0]  <= '0;
			radp_q[0] <= job.radp;
			radn_q[0] <= job.radn;
			okp_q[0]  <= job.okp;
			okn_q[0]  <= job.okn;
			b_q[0]    <= job.b;
			for (int k = 0; k < ROOT_W; k++) begin
				sqp_q[k+1]  <= sq_step(sqp_q[k], radp_q[k][RAD_W-1 -: 2]);
				sqn_q[k+1]  <= sq_step(sqn_q[k], radn_q[k][RAD_W-1 -: 2]);
				radp_q[k+1] <= {radp_q[k][RAD_W-3:0], 2'b00};
				radn_q[k+1] <= {radn_q[k][RAD_W-3:0], 2'b00};
				okp_q[k+1]  <= okp_q[k];
				okn_q[k+1]  <= okn_q[k];
				b_q[k+1]    <= b_q[k];
			end

			// positive acceleration keeps roots >= 0, negative keeps roots <= 0
			c_s1[0] <= '{v: okp_q[ROOT_W] && !np1_c[N_W-1], m: mag(np1_c)};
			c_s1[1] <= '{v: okp_q[ROOT_W] && !np2_c[N_W-1], m: mag(np2_c)};
			c_s1[2] <= '{v: okn_q[ROOT_W] && (nn1_c[N_W-1] || nn1_c == '0), m: mag(nn1_c)};
			c_s1[3] <= '{v: okn_q[ROOT_W] && (nn2_c[N_W-1] || nn2_c == '0), m: mag(nn2_c)};

			c_s2[0] <= pick(c_s1[0], c_s1[1]);
			c_s2[1] <= pick(c_s1[2], c_s1[3]);
			c_s3    <= pick(c_s2[0], c_s2[1]);

			dfd_q[0]  <= c_s3.v && accel != '0;
			drem_q[0] <= '0;
			dnq_q[0]  <= {c_s3.m, {FRAC_BITS{1'b0}}};
			for (int k = 0; k < NUM_W; k++) begin
				dfd_q[k+1] <= dfd_q[k];
				if ({drem_q[k][RW-2:0], dnq_q[k][NUM_W-1]} >= RW'(accel)) begin
					drem_q[k+1] <= {drem_q[k][RW-2:0], dnq_q[k][NUM_W-1]} - RW'(accel);
					dnq_q[k+1]  <= {dnq_q[k][NUM_W-2:0], 1'b1};
				end else begin
					drem_q[k+1] <= {drem_q[k][RW-2:0], dnq_q[k][NUM_W-1]};
					dnq_q[k+1]  <= {dnq_q[k][NUM_W-2:0], 1'b0};
				end
			end

			if (!dfd_q[NUM_W]) begin
				time_q  <= '0;
				nosol_q <= 1'b1;
				sat_q   <= 1'b0;
			end else if (|quo_c[NUM_W-1:32]) begin
				time_q  <= '1;
				nosol_q <= 1'b0;
				sat_q   <= 1'b1;
			end else begin
				time_q  <= quo_c[31:0];
				nosol_q <= 1'b0;
				sat_q   <= 1'b0;
			end
		end
	end

endmodule

[hw/rtl/min_time_double_integrator_1d_top.sv]
// channel  | dir | payload
// items    | in  | start_pos, end_pos, start_vel, end_vel (signed Q16.16)
// results  | out | min_time (Q16.16), no_solution, saturated
// apb      | in  | accel_limit at byte address 0
//
// One beat per cycle in and out unless stalled. A beat passes the front
// stages, the queue, 35 square root stages (34 root bits), 3 selection
// stages, 51 divider stages (50 quotient bits) and the output register.
// Reset clears all valid flags and sets accel_limit to 1.0; no clearing pass.
// A stalled result holds the back pipeline; the 4-entry queue lets the
// front keep taking beats until it fills.
module min_time_double_integrator_1d_top
	import mtdi_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	mtdi_in_if.sink           items,
	mtdi_out_if.source        results,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [ACCEL_W-1:0] accel;
	logic               push, full, pop, nonempty;
	job_t               push_data, pop_data;

	mtdi_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .accel(accel)
	);

	mtdi_front u_front (
		.clk(clk), .arst_n(arst_n), .items(items), .accel(accel),
		.full(full), .push(push), .job(push_data)
	);

	mtdi_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_data), .full(full),
		.pop(pop), .nonempty(nonempty), .pop_data(pop_data)
	);

	mtdi_back u_back (
		.clk(clk), .arst_n(arst_n), .accel(accel), .nonempty(nonempty),
		.job(pop_data), .pop(pop), .results(results)
	);

endmodule

[tb/mtdi_checker.sv]
`timescale 1ns / 1ps

module mtdi_checker
	import mtdi_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	mtdi_in_if                items,
	mtdi_out_if               results,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	input  logic              pready,
	output int                fails,
	output int                pending,
	output int                checked
);

	typedef struct packed {
		logic [31:0] min_time;
		logic        no_solution;
		logic        saturated;
	} arrival_t;

	arrival_t           arrival_q[$];
	logic [ACCEL_W-1:0] accel;

	// exact-width evaluation of both acceleration signs and all four roots
	function automatic arrival_t arrival_time(input logic signed [31:0] x0, x1, v0, v1,
			input logic [ACCEL_W-1:0] a);
		logic signed [127:0] sx0, sx1, sv0, sv1, sa, dx, w, b, n, sgn;
		logic [127:0]        rad, root, cand, t, best;
		bit                  found;
		arrival_t            res;
		res = '{min_time: '0, no_solution: 1'b1, saturated: 1'b0};
		found = 0;
		best = '0;
		if (a == '0)
			return res;
		sx0 = x0;
		sx1 = x1;
		sv0 = v0;
		sv1 = v1;
		sa = $signed({97'd0, a});
		dx = sx1 - sx0;
		b = -(sv0 + sv1);
		for (int s = 0; s < 2; s++) begin
			sgn = (s == 0) ? 128'sd1 : -128'sd1;
			w = sv0 * sv0 + sv1 * sv1 + 128'sd2 * sgn * sa * dx;
			if (w < 0)
				continue;
			rad = 2 * w;
			root = '0;
			for (int k = 33; k >= 0; k--) begin
				cand = root | (128'd1 << k);
				if (cand * cand <= rad)
					root = cand;
			end
			for (int j = 0; j < 2; j++) begin
				n = (j == 0) ? b + $signed(root) : b - $signed(root);
				if ((s == 0) ? (n < 0) : (n > 0))
					continue;
				t = (((n < 0) ? -n : n) << FRAC_BITS) / sa;
				if (!found || t < best) begin
					best = t;
					found = 1;
				end
			end
		end
		if (found) begin
			res.no_solution = 1'b0;
			if (best > 128'hFFFF_FFFF) begin
				res.min_time = 32'hFFFF_FFFF;
				res.saturated = 1'b1;
			end else begin
				res.min_time = best[31:0];
			end
		end
		return res;
	endfunction

	assign pending = arrival_q.size();

	always @(posedge clk or negedge arst_n) begin
		arrival_t got, exp_r;
		int       errs;
		if (!arst_n) begin
			accel <= ACCEL_RESET;
			fails <= 0;
			checked <= 0;
			arrival_q.delete();
		end else begin
			errs = 0;
			if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_ACCEL)
				accel <= pwdata[ACCEL_W-1:0];
			if (items.valid && items.ready)
				arrival_q = {arrival_q, arrival_time(items.start_pos, items.end_pos,
					items.start_vel, items.end_vel, accel)};
			if (results.valid && results.ready) begin
				got = '{min_time: results.min_time, no_solution: results.no_solution,
					saturated: results.saturated};
				checked <= checked + 1;
				if (arrival_q.size() == 0) begin
					$display("%0t: unexpected result beat min_time=%h no_solution=%b saturated=%b",
						$time, got.min_time, got.no_solution, got.saturated);
					errs++;
				end else begin
					exp_r = arrival_q.pop_front();
					if (got.min_time !== exp_r.min_time) begin
						$display("%0t: min_time expected %h actual %h",
							$time, exp_r.min_time, got.min_time);
						errs++;
					end
					if (got.no_solution !== exp_r.no_solution) begin
						$display("%0t: no_solution expected %b actual %b",
							$time, exp_r.no_solution, got.no_solution);
						errs++;
					end
					if (got.saturated !== exp_r.saturated) begin
						$display("%0t: saturated expected %b actual %b",
							$time, exp_r.saturated, got.saturated);
						errs++;
					end
				end
			end
			if (errs != 0)
				fails <= fails + errs;
		end
	end

endmodule

[tb/min_time_double_integrator_1d_top_test.sv]
`timescale 1ns / 1ps

module min_time_double_integrator_1d_top_test;
	import mtdi_pkg::*;

	localparam int DRAIN = 150;

	logic              clk;
	logic              arst_n;
	logic              psel, penable, pwrite, pready;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata, prdata;
	int                fails, pending, checked;
	int                sent, settings;
	bit                calm;

	mtdi_in_if  items_if();
	mtdi_out_if results_if();

	min_time_double_integrator_1d_top uut (
		.clk(clk), .arst_n(arst_n), .items(items_if), .results(results_if),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	mtdi_checker chk (
		.clk(clk), .arst_n(arst_n), .items(items_if), .results(results_if),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready), .fails(fails), .pending(pending),
		.checked(checked)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("Some tests failed");
		$finish;
	end

	task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		settings++;
	endtask

	task automatic send_beat(input logic [31:0] x0, x1, v0, v1);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			items_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		items_if.valid <= 1'b1;
		items_if.start_pos <= x0;
		items_if.end_pos <= x1;
		items_if.start_vel <= v0;
		items_if.end_vel <= v1;
		@(posedge clk);
		while (!items_if.ready)
			@(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	task automatic settle;
		items_if.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	function automatic logic [31:0] pick_field();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
			2: return 32'($signed($urandom_range(0, 32'h1FF_FFFF)) - 32'sh100_0000);
			default: case ($urandom_range(0, 4))
				0: return 32'h8000_0000;
				1: return 32'h7FFF_FFFF;
				2: return 32'h0;
				3: return 32'hFFFF_FFFF;
				default: return 32'h0001_0000;
			endcase
		endcase
	endfunction

	task automatic random_run(input int count);
		logic [31:0] x0;
		for (int i = 0; i < count; i++) begin
			calm = (i % 64) < 12;
			x0 = pick_field();
			// some beats share start and end position to hit the zero-distance path
			if ($urandom_range(0, 9) == 0)
				send_beat(x0, x0, pick_field(), pick_field());
			else
				send_beat(x0, pick_field(), pick_field(), pick_field());
		end
		calm = 0;
	endtask

	// receiver: random stalls per beat
	initial begin
		int stall;
		results_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = calm ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				results_if.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			results_if.ready <= 1'b1;
			@(posedge clk);
			while (!results_if.valid)
				@(posedge clk);
		end
	end

	initial begin
		logic [31:0] directed[20][4];
		directed = '{
			'{32'h0, 32'h0, 32'h0, 32'h0},
			'{32'h0001_0000, 32'h0, 32'h0, 32'h0},
			'{32'h0, 32'h0001_0000, 32'h0, 32'h0},
			'{32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000},
			'{32'h0, 32'h0, 32'hFFFF_0000, 32'h0001_0000},
			'{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0},
			'{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0},
			'{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000},
			'{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
			'{32'h0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF},
			'{32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000},
			'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
			'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
			'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
			'{32'h0, 32'h0, 32'h0, 32'h0000_0001},
			'{32'h0, 32'h0000_0001, 32'h0, 32'h0},
			'{32'h0, 32'h0010_0000, 32'h0004_0000, 32'hFFFC_0000},
			'{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA},
			'{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555},
			'{32'h1234_5678, 32'hEDCB_A988, 32'h0, 32'h7FFF_FFFF}
		};
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		items_if.valid = 1'b0;
		items_if.start_pos = '0;
		items_if.end_pos = '0;
		items_if.start_vel = '0;
		items_if.end_vel = '0;
		calm = 0;
		sent = 0;
		settings = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset acceleration of 1.0
		foreach (directed[i])
			send_beat(directed[i][0], directed[i][1], directed[i][2], directed[i][3]);
		random_run(140);
		settle();

		reg_write(3'd0, 32'd1);
		foreach (directed[i])
			send_beat(directed[i][0], directed[i][1], directed[i][2], directed[i][3]);
		random_run(140);
		settle();

		// top bit dropped: becomes the largest limit
		reg_write(3'd0, 32'hFFFF_FFFF);
		random_run(140);
		settle();

		// zero limit: nothing is reachable
		reg_write(3'd0, 32'd0);
		random_run(60);
		settle();

		reg_write(3'd0, 32'h0004_0000);
		// write to an unmapped register leaves the limit alone
		reg_write(3'd4, 32'd1);
		random_run(140);
		settle();

		for (int p = 0; p < 3; p++) begin
			reg_write(3'd0, $urandom_range(1, 32'h7FFF_FFFF));
			random_run(140);
			settle();
		end

		reg_write(3'd0, 32'h0001_0000);
		random_run(110);
		settle();

		$display("%0d item beats sent over %0d register writes, %0d result beats checked",
			sent, settings, checked);
		if (fails == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[files.f]
hw/rtl/mtdi_pkg.sv
hw/rtl/mtdi_in_if.sv
hw/rtl/mtdi_out_if.sv
hw/rtl/mtdi_cfg.sv
hw/rtl/mtdi_front.sv
hw/rtl/mtdi_fifo.sv
hw/rtl/mtdi_back.sv
hw/rtl/min_time_double_integrator_1d_top.sv
tb/mtdi_checker.sv
tb/min_time_double_integrator_1d_top_test.sv
